### rtl/q2e_pkg.sv
// Shared types, widths and the arctangent table of the quaternion-to-Euler bin pipeline.
`default_nettype none

package q2e_pkg;

  // Default number of bins per angle range
  localparam int unsigned ANGLE_STEPS_DEF = 18;

  // Field and datapath widths
  localparam int unsigned QW           = 16;  // quaternion component
  localparam int unsigned PW           = 32;  // component product
  localparam int unsigned OPW          = 34;  // atan2 operand
  localparam int unsigned SW           = 32;  // clamped pitch sine
  localparam int unsigned CW           = 38;  // CORDIC x/y
  localparam int unsigned AW           = 34;  // binary angle accumulator
  localparam int unsigned SQW          = 64;  // square root remainder/result
  localparam int unsigned BINW         = 5;   // bin field
  localparam int unsigned STEPW        = 8;   // bin count
  localparam int unsigned CORDIC_ITERS = 31;
  localparam int unsigned SQRT_CELLS   = 32;

  // One input item
  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  // One result item
  typedef struct packed {
    logic [BINW-1:0] roll_bin;
    logic [BINW-1:0] pitch_bin;
    logic [BINW-1:0] yaw_bin;
  } bins_t;

  // State handed along the CORDIC row
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 frz;  // angle settled by a special case
  } cord_t;

  // State handed along the square root row
  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [SQW-1:0] res;
  } sqrt_t;

  // atan(2^-i) in binary angle units, pi = 2^31
  function automatic logic signed [AW-1:0] atan_tab(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = '0;
    endcase
    return $signed({{(AW-32){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

### rtl/q2e_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
`default_nettype none

module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int unsigned BIT_POS  = 62,
  parameter int unsigned PAY_W    = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire sqrt_t            sqrt_i,
  input  wire logic [PAY_W-1:0] pay_i,
  output      sqrt_t            sqrt_o,
  output      logic [PAY_W-1:0] pay_o
);

  localparam logic [SQW-1:0] BitC = SQW'(1) << BIT_POS;

  sqrt_t          sqrt_d;
  sqrt_t          sqrt_q;
  logic [PAY_W-1:0] pay_q;
  logic [SQW-1:0] trial;

  // Try this digit against the remainder
  always_comb begin
    trial = sqrt_i.res + BitC;
    if (sqrt_i.rem >= trial) begin
      sqrt_d.rem = sqrt_i.rem - trial;
      sqrt_d.res = (sqrt_i.res >> 1) + BitC;
    end else begin
      sqrt_d.rem = sqrt_i.rem;
      sqrt_d.res = sqrt_i.res >> 1;
    end
  end

  // Advance with the pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqrt_q <= sqrt_d;
      pay_q  <= pay_i;
    end
  end

  assign sqrt_o = sqrt_q;
  assign pay_o  = pay_q;

endmodule

`default_nettype wire

### rtl/q2e_cordic_cell.sv
// One vectoring iteration of the CORDIC arctangent row.
`default_nettype none

module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire cord_t cell_i,
  output      cord_t cell_o
);

  logic signed [CW-1:0] xc;
  logic signed [CW-1:0] yc;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cord_t                cell_d;
  cord_t                cell_q;

  // Rotate towards the x axis, floor shifts
  always_comb begin
    xc     = cell_i.x;
    yc     = cell_i.y;
    xs     = xc >>> IDX;
    ys     = yc >>> IDX;
    cell_d = cell_i;
    if (!cell_i.frz) begin
      if (!yc[CW-1]) begin
        cell_d.x   = xc + ys;
        cell_d.y   = yc - xs;
        cell_d.acc = cell_i.acc + atan_tab(IDX);
      end else begin
        cell_d.x   = xc - ys;
        cell_d.y   = yc + xs;
        cell_d.acc = cell_i.acc - atan_tab(IDX);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

### rtl/q2e_angle_lane.sv
// atan2 lane: special cases and quadrant fold, then a row of CORDIC cells.
`default_nettype none

module q2e_angle_lane
  import q2e_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [OPW-1:0] y_i,
  input  wire logic signed [OPW-1:0] x_i,
  output      logic signed [AW-1:0]  ang_o
);

  localparam logic signed [AW-1:0] Quarter = AW'(64'sd1073741824);
  localparam logic signed [AW-1:0] Half    = AW'(64'sd2147483648);

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  cord_t                pre_d;
  cord_t                pre_q;
  cord_t                chain [CORDIC_ITERS+1];
  logic signed [AW-1:0] acc_end;

  // Settle axis cases, fold the left half plane
  always_comb begin
    xe        = CW'(x_i);
    ye        = CW'(y_i);
    pre_d.x   = xe;
    pre_d.y   = ye;
    pre_d.acc = '0;
    pre_d.frz = 1'b0;
    priority if (y_i == '0) begin
      pre_d.frz = 1'b1;
      pre_d.acc = x_i[OPW-1] ? Half : '0;
    end else if (x_i == '0) begin
      pre_d.frz = 1'b1;
      pre_d.acc = y_i[OPW-1] ? -Quarter : Quarter;
    end else if (x_i[OPW-1]) begin
      if (!y_i[OPW-1]) begin
        pre_d.x   = ye;
        pre_d.y   = -xe;
        pre_d.acc = Quarter;
      end else begin
        pre_d.x   = -ye;
        pre_d.y   = xe;
        pre_d.acc = -Quarter;
      end
    end else begin
      pre_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
    end
  end

  assign chain[0] = pre_q;

  // Row of iteration cells
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    q2e_cordic_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .cell_i(chain[i]),
      .cell_o(chain[i+1])
    );
  end

  // Clamp to a half turn either way
  always_comb begin
    acc_end = chain[CORDIC_ITERS].acc;
    priority if (acc_end > Half) begin
      ang_o = Half;
    end else if (acc_end < -Half) begin
      ang_o = -Half;
    end else begin
      ang_o = acc_end;
    end
  end

endmodule

`default_nettype wire

### rtl/quaternion_to_euler_bins.sv
// Top level: quaternion products, pitch square root row, three atan2 lanes and binning.
`default_nettype none

// Converts one Q1.15 unit quaternion per cycle into coarse roll, pitch and yaw bins.
// From input accept to result valid an item passes the product, operand and square
// root argument registers, 32 square root cells for the pitch cosine, a fold
// register and 31 CORDIC cells per atan2 lane, and one binning register that is
// also the output register. Throughput is one item per cycle; the whole pipe holds
// while a result waits on out_stall_i, and in_stall_o rises only then. No reset sweep is needed.
module quaternion_to_euler_bins
  import q2e_pkg::*;
#(
  parameter int unsigned ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_stall_o,
  input  wire quat_t in_data_i,
  output      logic  out_valid_o,
  input  wire logic  out_stall_i,
  output      bins_t out_data_o
);

  localparam int unsigned LAT     = 3 + SQRT_CELLS + 1 + CORDIC_ITERS + 1;
  localparam int unsigned PAYW    = 4 * OPW + SW;
  localparam logic [STEPW-1:0] StepsV = STEPW'(ANGLE_STEPS);
  localparam logic signed [OPW-1:0] OneQ = OPW'(64'sd1073741824);
  localparam logic signed [AW:0] HalfR = (AW+1)'(64'sd2147483648);
  localparam logic signed [AW:0] HalfP = (AW+1)'(64'sd1073741824);
  localparam logic signed [AW:0] TopR  = (AW+1)'(64'sd4294967296);
  localparam logic signed [AW:0] TopP  = (AW+1)'(64'sd2147483648);

  logic            adv;
  logic [LAT-1:0]  vld_q;
  logic [LAT-1:0]  vld_d;

  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0] wx_q, yz_q, wz_q, xy_q, wy_q, zx_q, xx_q, yy_q, zz_q;

  logic signed [OPW-1:0] rn_d, rd_d, yn_d, yd_d, sd_wide;
  logic signed [SW-1:0]  s_d;
  logic signed [OPW-1:0] rn_q, rd_q, yn_q, yd_q;
  logic signed [SW-1:0]  s_q;

  logic signed [2*SW-1:0] sq;
  sqrt_t                  sqrt0_q;
  logic [PAYW-1:0]        pay0_q;

  sqrt_t           sq_chain  [SQRT_CELLS+1];
  logic [PAYW-1:0] pay_chain [SQRT_CELLS+1];

  logic signed [OPW-1:0] rn_e, rd_e, yn_e, yd_e, s_e, c_e;
  logic signed [SW-1:0]  s_end;
  logic signed [AW-1:0]  roll_ang, pitch_ang, yaw_ang;
  bins_t                 bins_d;
  bins_t                 bins_q;

  // Bias, clamp and scale a binary angle to a bin
  function automatic logic [BINW-1:0] to_bin(input logic signed [AW-1:0] ang,
                                             input logic pitch);
    logic signed [AW:0] u;
    logic [32:0]        uc;
    logic [40:0]        prod;
    logic [40:0]        b;
    u = {ang[AW-1], ang} + (pitch ? HalfP : HalfR);
    priority if (u < 0) begin
      uc = '0;
    end else if (u > (pitch ? TopP : TopR)) begin
      uc = (pitch ? TopP[32:0] : TopR[32:0]);
    end else begin
      uc = u[32:0];
    end
    prod = 41'(uc) * 41'(StepsV);
    b    = pitch ? (prod >> 31) : (prod >> 32);
    if (b > 41'(StepsV)) begin
      b = 41'(StepsV);
    end
    return b[BINW-1:0];
  endfunction

  // Advance the whole pipe unless a result is held
  assign adv        = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign vld_d      = {vld_q[LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: component products
  assign qw = in_data_i.quat_w;
  assign qx = in_data_i.quat_x;
  assign qy = in_data_i.quat_y;
  assign qz = in_data_i.quat_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q <= qw * qx;
      yz_q <= qy * qz;
      wz_q <= qw * qz;
      xy_q <= qx * qy;
      wy_q <= qw * qy;
      zx_q <= qz * qx;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
    end
  end

  // Stage 2: atan2 operands and clamped pitch sine
  always_comb begin
    rn_d    = (OPW'(wx_q) + OPW'(yz_q)) <<< 1;
    rd_d    = OneQ - ((OPW'(xx_q) + OPW'(yy_q)) <<< 1);
    yn_d    = (OPW'(wz_q) + OPW'(xy_q)) <<< 1;
    yd_d    = OneQ - ((OPW'(yy_q) + OPW'(zz_q)) <<< 1);
    sd_wide = (OPW'(wy_q) - OPW'(zx_q)) <<< 1;
    priority if (sd_wide > OneQ) begin
      s_d = SW'(OneQ);
    end else if (sd_wide < -OneQ) begin
      s_d = SW'(-OneQ);
    end else begin
      s_d = SW'(sd_wide);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rn_q <= rn_d;
      rd_q <= rd_d;
      yn_q <= yn_d;
      yd_q <= yd_d;
      s_q  <= s_d;
    end
  end

  // Stage 3: square root argument 2^60 - s^2
  assign sq = s_q * s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqrt0_q.rem <= (SQW'(1) << 60) - SQW'(sq);
      sqrt0_q.res <= '0;
      pay0_q      <= {rn_q, rd_q, yn_q, yd_q, s_q};
    end
  end

  // Square root row, one result digit per cell
  assign sq_chain[0]  = sqrt0_q;
  assign pay_chain[0] = pay0_q;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT_POS(62 - 2 * k),
      .PAY_W  (PAYW)
    ) u_sqrt (
      .clk_i (clk_i),
      .en_i  (adv),
      .sqrt_i(sq_chain[k]),
      .pay_i (pay_chain[k]),
      .sqrt_o(sq_chain[k+1]),
      .pay_o (pay_chain[k+1])
    );
  end

  // Unpack operands for the lanes
  assign {rn_e, rd_e, yn_e, yd_e, s_end} = pay_chain[SQRT_CELLS];
  assign s_e = OPW'(s_end);
  assign c_e = $signed({{(OPW-32){1'b0}}, sq_chain[SQRT_CELLS].res[31:0]});

  q2e_angle_lane u_roll (
    .clk_i(clk_i),
    .en_i (adv),
    .y_i  (rn_e),
    .x_i  (rd_e),
    .ang_o(roll_ang)
  );

  q2e_angle_lane u_pitch (
    .clk_i(clk_i),
    .en_i (adv),
    .y_i  (s_e),
    .x_i  (c_e),
    .ang_o(pitch_ang)
  );

  q2e_angle_lane u_yaw (
    .clk_i(clk_i),
    .en_i (adv),
    .y_i  (yn_e),
    .x_i  (yd_e),
    .ang_o(yaw_ang)
  );

  // Binning and output register
  always_comb begin
    bins_d.roll_bin  = to_bin(roll_ang, 1'b0);
    bins_d.pitch_bin = to_bin(pitch_ang, 1'b1);
    bins_d.yaw_bin   = to_bin(yaw_ang, 1'b0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bins_q <= bins_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_data_o  = bins_q;

`ifndef SYNTHESIS
  // A held pipe keeps every stage's occupancy
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipe occupancy changed while held");

  // An accepted item enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item lost at pipe entry");

  // Bins never exceed the step count
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ANGLE_STEPS > 31) ||
      ((32'(out_data_o.roll_bin) <= ANGLE_STEPS) &&
       (32'(out_data_o.pitch_bin) <= ANGLE_STEPS) &&
       (32'(out_data_o.yaw_bin) <= ANGLE_STEPS)))
    else $error("bin beyond step count");
`endif

endmodule

`default_nettype wire
